### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mp3s_pkg.sv
// ----------------------------------------------------------------------------
// mp3s_pkg
// Types, register indexes and float compare helpers for the 3x3/2 max pool.
// ----------------------------------------------------------------------------
`default_nettype none

package mp3s_pkg;

  localparam int PIX_W = 32;
  localparam int ROW_W = 16;
  localparam int COL_W = 10;

  localparam logic [PIX_W-1:0] LOWEST_FLOAT = 32'hFF7F_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_IN_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH   = 3'd1;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd2;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd3;
  localparam logic [2:0] REG_PAD_H      = 3'd4;
  localparam logic [2:0] REG_PAD_W      = 3'd5;

  // effective (clamped) configuration
  typedef struct packed {
    logic [15:0] in_height;
    logic [10:0] in_width;
    logic [15:0] out_height;
    logic [9:0]  out_width;
    logic [1:0]  pad_h;
    logic [1:0]  pad_w;
  } cfg_t;

  // one output column touched by a pixel
  typedef struct packed {
    logic             close;
    logic             par;
    logic [COL_W-1:0] ow;
    logic [PIX_W-1:0] val;
  } col_t;

  // one output row candidate of a pixel
  typedef struct packed {
    logic             emit;
    logic             inc1;
    logic             inc2;
    logic [ROW_W-1:0] oh;
  } row_t;

  // item handed from the front stage to the line-store stage
  typedef struct packed {
    col_t [1:0] col;
    row_t [1:0] row;
    logic [1:0] slot;
  } item_t;

  // three row lanes of one line-store entry
  typedef logic [2:0][PIX_W-1:0] lines_t;

  // ordered float greater-than on raw bits (no NaN)
  function automatic logic fgt(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic res;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) res = 1'b0;
    else if (a[31] != b[31])                  res = ~a[31];
    else if (!a[31])                          res = a[30:0] > b[30:0];
    else                                      res = a[30:0] < b[30:0];
    return res;
  endfunction

  // lane of the previous row
  function automatic logic [1:0] lane_prev1(logic [1:0] slot);
    logic [1:0] l;
    case (slot)
      2'd0:    l = 2'd2;
      2'd1:    l = 2'd0;
      2'd2:    l = 2'd1;
      default: l = 2'd0;
    endcase
    return l;
  endfunction

  // lane of the row two back
  function automatic logic [1:0] lane_prev2(logic [1:0] slot);
    logic [1:0] l;
    case (slot)
      2'd0:    l = 2'd1;
      2'd1:    l = 2'd2;
      2'd2:    l = 2'd0;
      default: l = 2'd0;
    endcase
    return l;
  endfunction

  // vertical max over the window rows; current row wins ties, then newest
  function automatic logic [PIX_W-1:0] col_max(lines_t w, logic [PIX_W-1:0] cur,
                                              logic [1:0] slot, logic inc1, logic inc2);
    logic [PIX_W-1:0] acc, v1, v2;
    acc = cur;
    v1  = w[lane_prev1(slot)];
    v2  = w[lane_prev2(slot)];
    if (inc1 && fgt(v1, acc)) acc = v1;
    if (inc2 && fgt(v2, acc)) acc = v2;
    return acc;
  endfunction

endpackage

`default_nettype wire

### hdl/max_pool_3x3_stride2_stream_top.sv
// ----------------------------------------------------------------------------
// max_pool_3x3_stride2_stream_top
// Streaming 3x3, stride-2 float32 max pooling of one raster-order image.
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  input   | in_valid, in_ready, in_pixel[31:0]           | in
//  result  | out_valid, out_ready, out_pooled, out_row,   | out
//          | out_col, out_last                            |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | in
//
//  One pixel per cycle: a read of the column bank on accept, the
//  read-modify-write and vertical max in the next stage, then the result buffer.
//  A pixel that closes several windows (row or image end) puts up to four items
//  out, one per cycle while out_ready is high; the input stalls only while the
//  buffer drains. Reset is synchronous; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_3x3_stride2_stream_top #(
  parameter int MAX_IN_WIDTH  = 1024,
  parameter int MAX_OUT_WIDTH = 513
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pooled,
  output logic [15:0]      out_row,
  output logic [9:0]       out_col,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mp3s_pkg::*;

  logic [15:0] in_height_r, out_height_r;
  logic [10:0] in_width_r;
  logic [9:0]  out_width_r;
  logic [1:0]  pad_h_r, pad_w_r;
  cfg_t        cfg;

  logic        acc, b_fire, b_valid;
  col_t [1:0]  acc_col;
  item_t       b_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r  <= 16'd8;
      in_width_r   <= 11'd8;
      out_height_r <= 16'd4;
      out_width_r  <= 10'd4;
      pad_h_r      <= 2'd1;
      pad_w_r      <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_HEIGHT:  in_height_r  <= cfg_data;
        REG_IN_WIDTH:   in_width_r   <= cfg_data[10:0];
        REG_OUT_HEIGHT: out_height_r <= cfg_data;
        REG_OUT_WIDTH:  out_width_r  <= cfg_data[9:0];
        REG_PAD_H:      pad_h_r      <= cfg_data[1:0];
        REG_PAD_W:      pad_w_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamp widths to the built storage
  always_comb begin
    cfg.in_height  = in_height_r;
    cfg.out_height = out_height_r;
    cfg.pad_h      = pad_h_r;
    cfg.pad_w      = pad_w_r;
    cfg.in_width   = (32'(in_width_r) > MAX_IN_WIDTH) ? 11'(MAX_IN_WIDTH) : in_width_r;
    cfg.out_width  = (32'(out_width_r) > MAX_OUT_WIDTH) ? 10'(MAX_OUT_WIDTH) : out_width_r;
  end

  mp3s_front #(.MAX_IN_WIDTH(MAX_IN_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_pixel  (in_pixel),
    .in_ready  (in_ready),
    .b_fire    (b_fire),
    .acc       (acc),
    .acc_col   (acc_col),
    .b_valid_r (b_valid),
    .b_item_r  (b_item)
  );

  mp3s_back #(.MAX_OUT_WIDTH(MAX_OUT_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .acc_col    (acc_col),
    .b_valid    (b_valid),
    .b_item     (b_item),
    .b_fire     (b_fire),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pooled (out_pooled),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

### hdl/mp3s_ram.sv
// ----------------------------------------------------------------------------
// mp3s_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/mp3s_front.sv
// ----------------------------------------------------------------------------
// mp3s_front
// Position counters, running horizontal maxima and window bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3s_front #(
  parameter int MAX_IN_WIDTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mp3s_pkg::cfg_t         cfg,
  input  wire logic                   in_valid,
  input  wire logic [31:0]            in_pixel,
  output logic                        in_ready,
  input  wire logic                   b_fire,
  output logic                        acc,
  output mp3s_pkg::col_t [1:0]        acc_col,
  output logic                        b_valid_r,
  output mp3s_pkg::item_t             b_item_r
);
  import mp3s_pkg::*;

  localparam int CW   = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int SW   = CW + 2;
  localparam int CMPW = (SW > 11) ? SW : 11;

  logic [CW-1:0]    col_r, col_nxt;
  logic [15:0]      row_r, row_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [1:0][31:0] part_r, part_nxt;
  item_t            item;

  logic [SW-1:0]    s, ow_hi, ow_lo;
  logic             lo_cand, hi_ok, lo_ok, c_zero, hi_open, lo_open, hi_close, lo_close;
  logic [CMPW-1:0]  c1, wx;
  logic [31:0]      p_hi, p_lo, new_hi, new_lo;
  logic [16:0]      t, r1, hx;
  logic [15:0]      oh_hi, oh_lo;
  logic             t_lo_cand;

  assign in_ready = !b_valid_r || b_fire;
  assign acc      = in_valid && in_ready;

  // horizontal candidates of this pixel
  always_comb begin
    s        = SW'(col_r) + SW'(cfg.pad_w);
    ow_hi    = s >> 1;
    ow_lo    = ow_hi - SW'(1);
    lo_cand  = !s[0] && (s >= SW'(2));
    hi_ok    = CMPW'(ow_hi) < CMPW'(cfg.out_width);
    lo_ok    = lo_cand && (CMPW'(ow_lo) < CMPW'(cfg.out_width));
    c_zero   = col_r == '0;
    hi_open  = !s[0] || c_zero;
    lo_open  = c_zero;
    c1       = CMPW'(col_r) + CMPW'(1);
    wx       = CMPW'(cfg.in_width);
    hi_close = c1 == wx;
    lo_close = c1 <= wx;
    p_hi     = part_r[ow_hi[0]];
    p_lo     = part_r[ow_lo[0]];
    new_hi   = (hi_open || fgt(in_pixel, p_hi)) ? in_pixel : p_hi;
    new_lo   = (lo_open || fgt(in_pixel, p_lo)) ? in_pixel : p_lo;
    part_nxt = part_r;
    if (lo_ok) part_nxt[ow_lo[0]] = new_lo;
    if (hi_ok) part_nxt[ow_hi[0]] = new_hi;
  end

  // vertical candidates and item assembly
  always_comb begin
    t         = 17'(row_r) + 17'(cfg.pad_h);
    r1        = 17'(row_r) + 17'd1;
    hx        = 17'(cfg.in_height);
    oh_hi     = 16'(t >> 1);
    oh_lo     = oh_hi - 16'd1;
    t_lo_cand = !t[0] && (t >= 17'd2);

    item.slot           = slot_r;
    item.col[0].close   = lo_ok && lo_close;
    item.col[0].par     = ow_lo[0];
    item.col[0].ow      = COL_W'(ow_lo);
    item.col[0].val     = new_lo;
    item.col[1].close   = hi_ok && hi_close;
    item.col[1].par     = ow_hi[0];
    item.col[1].ow      = COL_W'(ow_hi);
    item.col[1].val     = new_hi;
    item.row[0].emit    = t_lo_cand && (oh_lo < cfg.out_height) && (r1 <= hx);
    item.row[0].inc1    = row_r != 16'd0;
    item.row[0].inc2    = row_r > 16'd1;
    item.row[0].oh      = oh_lo;
    item.row[1].emit    = (oh_hi < cfg.out_height) && (r1 == hx);
    item.row[1].inc1    = t[0] && (row_r != 16'd0);
    item.row[1].inc2    = 1'b0;
    item.row[1].oh      = oh_hi;
    acc_col             = item.col;
  end

  // position advance
  always_comb begin
    col_nxt  = col_r + CW'(1);
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (c1 >= wx) begin
      col_nxt = '0;
      if (r1 >= hx) begin
        row_nxt  = 16'd0;
        slot_nxt = 2'd0;
      end else begin
        row_nxt  = 16'(r1);
        slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      slot_r    <= 2'd0;
      part_r    <= {LOWEST_FLOAT, LOWEST_FLOAT};
      b_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        slot_r    <= slot_nxt;
        part_r    <= part_nxt;
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // payload of the line-store stage
  always_ff @(posedge clk) begin
    if (acc) b_item_r <= item;
  end

`include "assert_macros.svh"
  `AST_IMPL(a_slot_row0, row_r == 16'd0, slot_r == 2'd0, "row slot out of step with row count")
  `AST_IMPL(a_col_par, b_valid_r && b_item_r.col[0].close && b_item_r.col[1].close, b_item_r.col[0].par != b_item_r.col[1].par, "two closing columns share a line-store bank")

endmodule

`default_nettype wire

### hdl/mp3s_back.sv
// ----------------------------------------------------------------------------
// mp3s_back
// Line-store read-modify-write in two column banks, vertical max and
// result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3s_back #(
  parameter int MAX_OUT_WIDTH = 513
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 acc,
  input  wire mp3s_pkg::col_t [1:0] acc_col,
  input  wire logic                 b_valid,
  input  wire mp3s_pkg::item_t      b_item,
  output logic                      b_fire,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_pooled,
  output logic [15:0]               out_row,
  output logic [9:0]                out_col,
  output logic                      out_last
);
  import mp3s_pkg::*;

  localparam int RDEPTH = (MAX_OUT_WIDTH + 1) / 2;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int LW     = 3 * PIX_W;

  logic   [1:0]          we, fwd_nxt;
  logic   [1:0]          fwd_r;
  logic   [1:0][RAW-1:0] waddr, raddr;
  lines_t [1:0]          wdata, rdata, fwd_data_r, word, new_word;

  logic   [3:0]          mask_new, mask_r;
  logic   [3:0][31:0]    res_val, val_r;
  logic   [3:0][15:0]    res_row, row_r;
  logic   [3:0][9:0]     res_col, colv_r;
  logic                  has_res, c_free;
  logic   [1:0]          sel;

  // column banks by parity
  for (genvar p = 0; p < 2; p++) begin : g_bank
    mp3s_ram #(.WIDTH(LW), .DEPTH(RDEPTH)) u_ram (
      .clk   (clk),
      .we    (we[p]),
      .waddr (waddr[p]),
      .wdata (wdata[p]),
      .re    (acc),
      .raddr (raddr[p]),
      .rdata (rdata[p])
    );
  end

  // read addresses of the item being accepted
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      raddr[p] = (acc_col[1].par == 1'(p)) ? RAW'(acc_col[1].ow >> 1)
                                            : RAW'(acc_col[0].ow >> 1);
    end
  end

  // merge: forwarded write data wins over a stale read
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      word[j]     = fwd_r[b_item.col[j].par] ? fwd_data_r[b_item.col[j].par]
                                             : rdata[b_item.col[j].par];
      new_word[j] = word[j];
      new_word[j][b_item.slot] = b_item.col[j].val;
    end
    for (int p = 0; p < 2; p++) begin
      we[p]    = 1'b0;
      waddr[p] = RAW'(b_item.col[0].ow >> 1);
      wdata[p] = new_word[0];
      if (b_item.col[0].close && b_item.col[0].par == 1'(p)) we[p] = b_fire;
      if (b_item.col[1].close && b_item.col[1].par == 1'(p)) begin
        we[p]    = b_fire;
        waddr[p] = RAW'(b_item.col[1].ow >> 1);
        wdata[p] = new_word[1];
      end
      fwd_nxt[p] = we[p] && (waddr[p] == raddr[p]);
    end
  end

  // results in row-major order of the candidates
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) begin
        mask_new[k*2+j] = b_valid && b_item.row[k].emit && b_item.col[j].close;
        res_val[k*2+j]  = col_max(word[j], b_item.col[j].val, b_item.slot,
                                  b_item.row[k].inc1, b_item.row[k].inc2);
        res_row[k*2+j]  = b_item.row[k].oh;
        res_col[k*2+j]  = b_item.col[j].ow;
      end
    end
    has_res = |mask_new;
    c_free  = (mask_r == 4'd0) || (((mask_r & (mask_r - 4'd1)) == 4'd0) && out_ready);
    b_fire  = b_valid && (!has_res || c_free);
  end

  // forwarding flags follow each read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 2'b00;
    end else if (acc) begin
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) fwd_data_r <= wdata;
  end

  // result buffer: up to four items, lowest set bit goes first
  always_comb begin
    sel = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (mask_r[i]) sel = 2'(i);
    end
  end

  assign out_valid  = |mask_r;
  assign out_pooled = val_r[sel];
  assign out_row    = row_r[sel];
  assign out_col    = colv_r[sel];
  assign out_last   = (mask_r & (mask_r - 4'd1)) == 4'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'd0;
    end else if (b_fire && has_res) begin
      mask_r <= mask_new;
    end else if (out_valid && out_ready) begin
      mask_r <= mask_r & (mask_r - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && has_res) begin
      val_r  <= res_val;
      row_r  <= res_row;
      colv_r <= res_col;
    end
  end

`include "assert_macros.svh"
  `AST_NEXT(a_buf_hold, out_valid && !out_ready, mask_r == $past(mask_r), "result buffer changed while stalled")
  `AST_IMPL(a_no_overrun, b_fire && has_res && (mask_r != 4'd0), out_ready, "result group loaded over pending items")

endmodule

`default_nettype wire
